FILE: rtl/bfr_pkg.sv
// Shared types and constants of the bitmap font text renderer.
// No dependencies; imported by the top level.
`default_nettype none

package bfr_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_PUT    = 2'd2
    } cmd_t;

    localparam int CELL_WIDTH   = 24;
    localparam int FIRST_CODE   = 32;
    localparam int END_CODE     = 127;
    localparam int NEWLINE_CODE = 10;
    localparam int GLYPH_COUNT  = END_CODE - FIRST_CODE;
    localparam int LANES        = 3;

    // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for every 14-bit x
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

endpackage

`default_nettype wire

FILE: rtl/bfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3990
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bitmap_font_text_renderer.sv
// Bitmap font text renderer on bfr_pkg and three bfr_ram lanes: font load, cursor, glyph writes.
// Printable character: busy in ST_DRAW until the final glyph row is out;
//   GLYPH_HEIGHT writes one a cycle, each behind the registered font read, paced by the one
//   font read port per lane. Writes cannot be stalled.
// Font load: busy one cycle. Cursor, newline and other codes: done at the accept edge.
// Reset clears cursor and sequencer; font store holds no defined value until loaded.
`default_nettype none

module bitmap_font_text_renderer
    import bfr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1080,
    parameter int SCREEN_HEIGHT = 1920,
    parameter int GLYPH_HEIGHT  = 42
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [13:0] font_index,
    input  wire logic [7:0]  font_byte,
    input  wire logic [7:0]  char_code,
    input  wire logic [31:0] ink_color,
    input  wire logic [5:0]  start_row,
    input  wire logic [5:0]  start_col,
    output logic             strobe,
    output logic [20:0]      pixel_index,
    output logic [23:0]      write_mask,
    output logic [31:0]      pixel_value,
    output logic             last
);

    localparam int ROWS        = SCREEN_HEIGHT / GLYPH_HEIGHT;
    localparam int COLS        = SCREEN_WIDTH / CELL_WIDTH;
    localparam int GLYPH_WORDS = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FONT_BYTES  = GLYPH_WORDS * LANES;
    localparam int AW          = $clog2(GLYPH_WORDS);
    localparam int RW          = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW          = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CPW         = $clog2((COLS - 1) * CELL_WIDTH + 2);
    localparam int GRW         = $clog2(GLYPH_HEIGHT + 1);
    localparam logic [20:0]    ROW_STEP  = 21'((GLYPH_HEIGHT * SCREEN_WIDTH) % (1 << 21));
    localparam logic [20:0]    LINE_STEP = 21'(SCREEN_WIDTH);
    localparam logic [GRW-1:0] GLYPH_ROWS = GRW'(GLYPH_HEIGHT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DRAW
    } state_t;

    state_t         state_reg, state_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [20:0]    row_pix_reg, row_pix_next;
    logic [CPW-1:0] col_pix_reg, col_pix_next;
    logic [GRW-1:0] rd_row_reg, rd_row_next;
    logic           valid_reg, valid_next;

    logic [12:0]    quot_reg, quot_next;
    logic [13:0]    idx_reg, idx_next;
    logic [7:0]     byte_reg, byte_next;
    logic [31:0]    color_reg, color_next;
    logic [AW-1:0]  glyph_base_reg, glyph_base_next;
    logic [20:0]    pix_acc_reg, pix_acc_next;

    logic           accept;
    logic [29:0]    div_prod;
    logic [13:0]    quot3;
    logic [1:0]     lane;
    logic [26:0]    row_prod;
    logic [AW-1:0]  rd_addr;
    logic [23:0]    ram_q;
    logic           issue;

    // cursor after a newline and after a plain advance
    logic [RW-1:0]  nl_row, adv_row;
    logic [CW-1:0]  adv_col;
    logic [20:0]    nl_row_pix, adv_row_pix;
    logic [CPW-1:0] adv_col_pix;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign div_prod = 30'(font_index) * 30'(DIV3_RECIP);
    assign quot3    = 14'({1'b0, quot_reg} + {quot_reg, 1'b0});
    assign lane     = 2'(idx_reg - quot3);
    assign row_prod = 27'(start_row) * 27'(ROW_STEP);
    assign rd_addr  = glyph_base_reg + AW'(rd_row_reg);
    assign issue    = (state_reg == ST_DRAW) && (rd_row_reg < GLYPH_ROWS);

    always_comb
    begin
        if (32'(row_reg) + 1 < ROWS)
        begin
            nl_row     = row_reg + RW'(1);
            nl_row_pix = row_pix_reg + ROW_STEP;
        end
        else
        begin
            nl_row     = row_reg;
            nl_row_pix = row_pix_reg;
        end
        if (32'(col_reg) + 1 >= COLS)
        begin
            adv_row     = nl_row;
            adv_row_pix = nl_row_pix;
            adv_col     = '0;
            adv_col_pix = '0;
        end
        else
        begin
            adv_row     = row_reg;
            adv_row_pix = row_pix_reg;
            adv_col     = col_reg + CW'(1);
            adv_col_pix = col_pix_reg + CPW'(CELL_WIDTH);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        row_pix_next    = row_pix_reg;
        col_pix_next    = col_pix_reg;
        rd_row_next     = rd_row_reg;
        valid_next      = 1'b0;
        quot_next       = quot_reg;
        idx_next        = idx_reg;
        byte_next       = byte_reg;
        color_next      = color_reg;
        glyph_base_next = glyph_base_reg;
        pix_acc_next    = pix_acc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_LOAD:
                        begin
                            quot_next = div_prod[29:DIV3_SHIFT];
                            idx_next  = font_index;
                            byte_next = font_byte;
                            if (32'(font_index) < FONT_BYTES)
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                        CMD_CURSOR:
                        begin
                            if (32'(start_row) < ROWS && 32'(start_col) < COLS)
                            begin
                                row_next     = RW'(start_row);
                                col_next     = CW'(start_col);
                                row_pix_next = row_prod[20:0];
                                col_pix_next = CPW'(32'(start_col) * CELL_WIDTH);
                            end
                        end
                        CMD_PUT:
                        begin
                            color_next      = ink_color;
                            glyph_base_next = AW'(32'(char_code - 8'(FIRST_CODE))
                                                  * GLYPH_HEIGHT);
                            pix_acc_next    = row_pix_reg + 21'(col_pix_reg);
                            rd_row_next     = '0;
                            priority if (32'(char_code) == NEWLINE_CODE)
                            begin
                                row_next     = nl_row;
                                row_pix_next = nl_row_pix;
                                col_next     = '0;
                                col_pix_next = '0;
                            end
                            else if (32'(char_code) >= FIRST_CODE &&
                                     32'(char_code) < END_CODE)
                            begin
                                state_next = ST_DRAW;
                            end
                            else
                            begin
                                row_next     = adv_row;
                                row_pix_next = adv_row_pix;
                                col_next     = adv_col;
                                col_pix_next = adv_col_pix;
                            end
                        end
                        default:
                        begin
                            // unknown command: drop it
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_DRAW:
            begin
                if (issue)
                begin
                    rd_row_next = rd_row_reg + GRW'(1);
                    valid_next  = 1'b1;
                end
                if (valid_reg)
                begin
                    pix_acc_next = pix_acc_reg + LINE_STEP;
                end
                if (valid_reg && rd_row_reg == GLYPH_ROWS)
                begin
                    // final glyph row out: move the cursor on
                    state_next   = ST_IDLE;
                    row_next     = adv_row;
                    row_pix_next = adv_row_pix;
                    col_next     = adv_col;
                    col_pix_next = adv_col_pix;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            row_pix_reg <= '0;
            col_pix_reg <= '0;
            rd_row_reg  <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            row_pix_reg <= row_pix_next;
            col_pix_reg <= col_pix_next;
            rd_row_reg  <= rd_row_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg       <= quot_next;
        idx_reg        <= idx_next;
        byte_reg       <= byte_next;
        color_reg      <= color_next;
        glyph_base_reg <= glyph_base_next;
        pix_acc_reg    <= pix_acc_next;
    end

    // one lane per byte of a glyph row; lane 0 holds the leftmost eight pixels
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bfr_ram #(
            .WIDTH (8),
            .DEPTH (GLYPH_WORDS)
        ) u_ram (
            .clk   (clk),
            .we    ((state_reg == ST_LOAD) && (lane == 2'(i))),
            .waddr (AW'(quot_reg)),
            .wdata (byte_reg),
            .raddr (rd_addr),
            .rdata (ram_q[23 - 8 * i -: 8])
        );
    end

    assign strobe      = valid_reg;
    assign pixel_index = pix_acc_reg;
    assign write_mask  = ram_q;
    assign pixel_value = color_reg;
    assign last        = valid_reg && (rd_row_reg == GLYPH_ROWS);

endmodule

`default_nettype wire

FILE: rtl/bfr_checker.sv
// Port-level checks on the renderer's write bursts, bound to the top level.
// Depends on bitmap_font_text_renderer's port names only.
`default_nettype none

module bfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        strobe,
    input wire logic        last,
    input wire logic [31:0] pixel_value
);

    // a write beat only comes out of a running command
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("write beat while not busy");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without a write beat");

    // a glyph burst has no gaps
    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a glyph burst");

    a_burst_color: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> $stable(pixel_value))
        else $error("color changed inside a glyph burst");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last |=> !busy)
        else $error("still busy after the final glyph row");

endmodule

bind bitmap_font_text_renderer bfr_checker u_bfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .strobe      (strobe),
    .last        (last),
    .pixel_value (pixel_value)
);

`default_nettype wire
